/* rtl/core/lzte_pkg.sv */
// Shared types and constants for the LZO1X token byte emitter.
// Used by the front end, plan queue, back end and top level.
package lzte_pkg;

    localparam logic [12:0] MAX_RUN    = 13'd8191;
    localparam logic [15:0] WINDOW_MAX = 16'd49151;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] END_HEAD = 8'h11;

    typedef enum logic [2:0] {
        ACT_LIT_HDR   = 3'd0,
        ACT_LIT_FINAL = 3'd1,
        ACT_LIT_BYTE  = 3'd2,
        ACT_MATCH     = 3'd3,
        ACT_END       = 3'd4
    } t_action;

    // Byte plan for one input item, emitted in field order:
    // two released held bytes, one head byte, zero-run extension, two end zeros.
    typedef struct packed {
        logic        rel_en;
        logic [7:0]  rel_hi;
        logic [7:0]  rel_lo;
        logic        head_en;
        logic [7:0]  head;
        logic        ext_en;
        logic [12:0] ext_rest;
        logic        end_en;
    } t_plan;

    typedef enum logic [2:0] {
        P_IDLE,
        P_REL_HI,
        P_REL_LO,
        P_HEAD,
        P_EXT,
        P_END1,
        P_END2
    } t_phase;

endpackage

/* rtl/core/lzte_front.sv */
// Front end: accepts tokens, keeps the held match bytes and stream state,
// and turns each token into a byte plan. Depends on lzte_pkg.
module lzte_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [2:0]         i_action,
    input  logic [12:0]        i_lit_count,
    input  logic [7:0]         i_lit_byte,
    input  logic [15:0]        i_match_offset,
    input  logic [12:0]        i_match_length,
    output logic               o_push,
    output lzte_pkg::t_plan    o_plan
);

    logic [15:0] r_held;
    logic        r_held_valid;
    logic        r_any;

    logic [15:0] n_held;
    logic        n_held_valid;
    logic        n_any;

    lzte_pkg::t_plan w_plan;
    logic            w_nonempty;

    always_comb begin
        logic [12:0] lit_len;
        logic [15:0] off_c;
        logic [12:0] m_len;
        logic [12:0] m_len_m1;
        logic [12:0] m_len_m2;
        logic [15:0] o_m;
        logic [15:0] o_far;

        lit_len  = (i_lit_count > lzte_pkg::MAX_RUN) ? lzte_pkg::MAX_RUN : i_lit_count;
        off_c    = (i_match_offset == 16'd0) ? 16'd1 : i_match_offset;
        off_c    = (off_c > lzte_pkg::WINDOW_MAX) ? lzte_pkg::WINDOW_MAX : off_c;
        m_len    = (i_match_length < 13'd4) ? 13'd4 : i_match_length;
        m_len    = (m_len > lzte_pkg::MAX_RUN) ? lzte_pkg::MAX_RUN : m_len;
        m_len_m1 = m_len - 13'd1;
        m_len_m2 = m_len - 13'd2;
        o_m      = off_c - 16'd1;
        o_far    = off_c - 16'h4000;

        w_plan          = '0;
        w_plan.rel_hi   = r_held[15:8];
        w_plan.rel_lo   = r_held[7:0];
        n_held          = r_held;
        n_held_valid    = r_held_valid;
        n_any           = r_any;

        case (lzte_pkg::t_action'(i_action))
            lzte_pkg::ACT_LIT_HDR, lzte_pkg::ACT_LIT_FINAL: begin
                if (lit_len == 13'd0) begin
                    w_plan.rel_en = r_held_valid;
                end else if ((lzte_pkg::t_action'(i_action) == lzte_pkg::ACT_LIT_FINAL)
                             && !r_any && (lit_len <= 13'd238)) begin
                    w_plan.rel_en  = r_held_valid;
                    w_plan.head_en = 1'b1;
                    w_plan.head    = 8'(lit_len + 13'd17);
                end else if (lit_len <= 13'd3) begin
                    // fold the short run into the first held byte
                    w_plan.rel_en = r_held_valid;
                    w_plan.rel_hi = r_held[15:8] | {6'd0, lit_len[1:0]};
                end else begin
                    w_plan.rel_en  = r_held_valid;
                    w_plan.head_en = 1'b1;
                    if (lit_len <= 13'd18) begin
                        w_plan.head = 8'(lit_len - 13'd3);
                    end else begin
                        w_plan.head     = 8'h00;
                        w_plan.ext_en   = 1'b1;
                        w_plan.ext_rest = lit_len - 13'd18;
                    end
                end
                if (w_plan.rel_en) begin
                    n_held_valid = 1'b0;
                    n_held       = '0;
                end
            end
            lzte_pkg::ACT_LIT_BYTE: begin
                w_plan.rel_en  = r_held_valid;
                w_plan.head_en = 1'b1;
                w_plan.head    = i_lit_byte;
                n_held_valid   = 1'b0;
                n_held         = '0;
            end
            lzte_pkg::ACT_MATCH: begin
                w_plan.rel_en = r_held_valid;
                n_held_valid  = 1'b1;
                n_any         = 1'b1;
                if ((m_len <= 13'd8) && (off_c <= 16'h0800)) begin
                    n_held = {m_len_m1[2:0], o_m[2:0], 2'b00, o_m[10:3]};
                end else if (off_c <= 16'h4000) begin
                    w_plan.head_en = 1'b1;
                    if (m_len <= 13'd33) begin
                        w_plan.head = {3'b001, m_len_m2[4:0]};
                    end else begin
                        w_plan.head     = 8'h20;
                        w_plan.ext_en   = 1'b1;
                        w_plan.ext_rest = m_len - 13'd33;
                    end
                    n_held = {o_m[5:0], 2'b00, o_m[13:6]};
                end else begin
                    w_plan.head_en = 1'b1;
                    if (m_len <= 13'd9) begin
                        w_plan.head = {4'b0001, o_far[14], m_len_m2[2:0]};
                    end else begin
                        w_plan.head     = {4'b0001, o_far[14], 3'b000};
                        w_plan.ext_en   = 1'b1;
                        w_plan.ext_rest = m_len - 13'd9;
                    end
                    n_held = {o_far[5:0], 2'b00, o_far[13:6]};
                end
            end
            lzte_pkg::ACT_END: begin
                w_plan.rel_en  = r_held_valid;
                w_plan.head_en = 1'b1;
                w_plan.head    = lzte_pkg::END_HEAD;
                w_plan.end_en  = 1'b1;
                n_held_valid   = 1'b0;
                n_held         = '0;
            end
            default: begin
                w_plan = '0;
            end
        endcase

        w_nonempty = w_plan.rel_en | w_plan.head_en;
        if (w_nonempty && (lzte_pkg::t_action'(i_action) != lzte_pkg::ACT_END)) begin
            n_any = 1'b1;
        end
        // end mark starts a fresh stream
        if (lzte_pkg::t_action'(i_action) == lzte_pkg::ACT_END) begin
            n_any = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held       <= '0;
            r_held_valid <= 1'b0;
            r_any        <= 1'b0;
        end else if (i_accept) begin
            r_held       <= n_held;
            r_held_valid <= n_held_valid;
            r_any        <= n_any;
        end
    end

    assign o_push = i_accept & w_nonempty;
    assign o_plan = w_plan;

endmodule

/* rtl/core/lzte_queue.sv */
// Short register queue of byte plans between front and back end.
// Depends on lzte_pkg for the plan type and depth.
module lzte_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  lzte_pkg::t_plan i_plan,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output lzte_pkg::t_plan o_plan
);

    lzte_pkg::t_plan r_mem [lzte_pkg::QUEUE_DEPTH];
    logic [lzte_pkg::QPTR_W-1:0] r_wr_ptr;
    logic [lzte_pkg::QPTR_W-1:0] r_rd_ptr;
    logic [lzte_pkg::QPTR_W:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_plan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_full  = (r_count == (lzte_pkg::QPTR_W+1)'(lzte_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_plan  = r_mem[r_rd_ptr];

endmodule

/* rtl/core/lzte_back.sv */
// Back end: walks one byte plan at a time and drives the output channel,
// one byte per beat. Depends on lzte_pkg.
module lzte_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  lzte_pkg::t_plan i_q_plan,
    output logic            o_pop,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic [7:0]      o_out_byte,
    output logic            o_last
);

    lzte_pkg::t_phase r_phase;
    lzte_pkg::t_plan  r_plan;
    logic [12:0]      r_rest;

    lzte_pkg::t_phase n_phase;
    lzte_pkg::t_plan  n_plan;
    logic [12:0]      n_rest;

    lzte_pkg::t_phase w_seg_next;
    logic             w_seg_done;
    logic             w_fire;

    // outputs and segment sequencing
    always_comb begin
        o_out_valid = (r_phase != lzte_pkg::P_IDLE);
        o_out_byte  = 8'h00;
        w_seg_done  = 1'b1;
        w_seg_next  = lzte_pkg::P_IDLE;
        case (r_phase)
            lzte_pkg::P_REL_HI: begin
                o_out_byte = r_plan.rel_hi;
                w_seg_next = lzte_pkg::P_REL_LO;
            end
            lzte_pkg::P_REL_LO: begin
                o_out_byte = r_plan.rel_lo;
                w_seg_next = r_plan.head_en ? lzte_pkg::P_HEAD : lzte_pkg::P_IDLE;
            end
            lzte_pkg::P_HEAD: begin
                o_out_byte = r_plan.head;
                if (r_plan.ext_en) begin
                    w_seg_next = lzte_pkg::P_EXT;
                end else if (r_plan.end_en) begin
                    w_seg_next = lzte_pkg::P_END1;
                end
            end
            lzte_pkg::P_EXT: begin
                // a zero for every full 255, then the remainder
                w_seg_done = (r_rest <= 13'd255);
                o_out_byte = w_seg_done ? r_rest[7:0] : 8'h00;
            end
            lzte_pkg::P_END1: begin
                w_seg_next = lzte_pkg::P_END2;
            end
            lzte_pkg::P_END2: begin
                w_seg_next = lzte_pkg::P_IDLE;
            end
            default: begin
                w_seg_next = lzte_pkg::P_IDLE;
            end
        endcase
        o_last = o_out_valid & w_seg_done & (w_seg_next == lzte_pkg::P_IDLE);
        w_fire = o_out_valid & i_out_ready;
    end

    // next state
    always_comb begin
        n_phase = r_phase;
        n_plan  = r_plan;
        n_rest  = r_rest;
        o_pop   = 1'b0;
        if ((r_phase == lzte_pkg::P_IDLE) || (w_fire && o_last)) begin
            if (i_q_valid) begin
                o_pop   = 1'b1;
                n_plan  = i_q_plan;
                n_rest  = i_q_plan.ext_rest;
                n_phase = i_q_plan.rel_en ? lzte_pkg::P_REL_HI : lzte_pkg::P_HEAD;
            end else begin
                n_phase = lzte_pkg::P_IDLE;
            end
        end else if (w_fire) begin
            if (!w_seg_done) begin
                n_rest = r_rest - 13'd255;
            end else begin
                n_phase = w_seg_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= lzte_pkg::P_IDLE;
        end else begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        r_plan <= n_plan;
        r_rest <= n_rest;
    end

endmodule

/* rtl/core/lz_token_byte_emitter_unit.sv */
// LZO1X token byte emitter. Each accepted token is turned into a byte plan at
// once and queued; the back end then sends one byte per output beat, the last
// byte of each token flagged with o_last. With no match bytes held, a literal
// byte token yields one byte, so a run of them streams at one token per cycle
// while the output is ready. A token's bytes leave without gaps; zero-run
// length extensions add a zero byte per full 255 of length. The two-entry
// plan queue lets input go on; empty tokens queue no plan. Depends on lzte_pkg.
module lz_token_byte_emitter_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_action,
    input  logic [12:0] i_lit_count,
    input  logic [7:0]  i_lit_byte,
    input  logic [15:0] i_match_offset,
    input  logic [12:0] i_match_length,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_last
);

    logic            w_full;
    logic            w_accept;
    logic            w_push;
    lzte_pkg::t_plan w_push_plan;
    logic            w_q_valid;
    lzte_pkg::t_plan w_q_plan;
    logic            w_pop;

    assign o_in_ready = ~w_full;
    assign w_accept   = i_in_valid & ~w_full;

    lzte_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (w_accept),
        .i_action       (i_action),
        .i_lit_count    (i_lit_count),
        .i_lit_byte     (i_lit_byte),
        .i_match_offset (i_match_offset),
        .i_match_length (i_match_length),
        .o_push         (w_push),
        .o_plan         (w_push_plan)
    );

    lzte_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_plan  (w_push_plan),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_plan  (w_q_plan)
    );

    lzte_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q_plan    (w_q_plan),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_byte  (o_out_byte),
        .o_last      (o_last)
    );

endmodule

/* rtl/core/lzte_checker.sv */
// Port-level checks for the token byte emitter, bound to the top level.
// Sees only the top-level ports.
module lzte_port_checks (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [7:0]  o_out_byte,
    input logic        o_last
);

    // a stalled beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_byte) && $stable(o_last))
        else $error("output payload changed while stalled");

    // bytes of one token leave without gaps
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_last |=> o_out_valid)
        else $error("gap inside one token's bytes");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid straight after reset");

endmodule

bind lz_token_byte_emitter_unit lzte_port_checks u_lzte_port_checks (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_byte  (o_out_byte),
    .o_last      (o_last)
);
